// ===== src/otwk_pkg.sv =====
`default_nettype none

package otwk_pkg;

  // Default resolution of the sine table index.
  localparam int SINE_INDEX_BITS_DEF = 10;

  // Reset value of the wheel lever scale, 1.0 in unsigned Q8.8.
  localparam logic [15:0] LEVER_RESET = 16'd256;

  // Angles are kept in hundredths of a degree.
  localparam int FULL_CIRCLE = 36000;
  localparam int SIXTY_DEG   = 6000;

  // The index quantizer works on angle * 2^(N-5); the full circle is then
  // 1125 * 2^N and half a step is 562.5, of which the half never matters.
  localparam int STEP_DIV  = 1125;
  localparam int STEP_HALF = 562;

  // Fixed point constants for the table build, unsigned Q2.30.
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Values that travel beside the angle path down the pipeline.
  typedef struct packed {
    logic signed [11:0] vx;
    logic signed [11:0] vy;
    logic signed [28:0] lever_turn;
  } side_t;

  // Magnitude of sin(r quarter steps) in Q1.15, from a Taylor series in
  // Q2.30 with truncated products. Evaluated while the design elaborates.
  function automatic logic [14:0] quarter_sine(input int unsigned r,
                                               input int unsigned nbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] v;
    x  = (64'(r) * PI_HALF_Q30) >> (nbits - 2);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int i = 0; i < 5; i++) begin
      case (i)
        0: t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        1: t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        2: t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        3: t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        default: t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      endcase
    end
    v = (x * t) >> 30;
    v = (v + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/omni_three_wheel_kinematics_top.sv =====
`default_nettype none

// Field-oriented inverse kinematics for a three-wheel omni base.
// Input words arrive on the s_axis channel: heading, field-frame speeds
// speed_x and speed_y, turn rate, and in tuser a flag that captures the
// current heading as the reference. The first word after reset always
// captures its heading. Each input word yields exactly one output word
// on m_axis with the three saturated wheel speeds; tuser flags that at
// least one of them was clipped.
// The lever scale (unsigned Q8.8) resets to 1.0 and is written through
// cfg_wr_en_i and cfg_wr_data_i; the user must write it only while no word
// is in flight, which the block does not enforce. A new word can be taken
// every cycle while m_axis_tready is high, so the sustained rate is one
// word per clock. The ten stages are: reference subtract and lever multiply,
// circle wrap, the three wheel angles, reciprocal multiply, remainder,
// index correction, sine and cosine table lookup, speed multiplies, wheel
// sums, and rounding with saturation into the output register.
// Each stage holds a valid bit; a stage only stalls when it is full and
// the one after it cannot move, so a stalled receiver fills the bubbles
// first and only then drops s_axis_tready. Reset empties the pipeline and
// clears the reference; nothing is lost or repeated across a stall.
module omni_three_wheel_kinematics_top #(
  parameter int SINE_INDEX_BITS = otwk_pkg::SINE_INDEX_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [15:0] cfg_wr_data_i,   // wheel_lever_scale
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // heading[15:0], speed_x[27:16], speed_y[39:28], turn_rate[51:40], zero
  input  wire logic [55:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,    // capture_reference
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // wheel_speed_a[15:0], wheel_speed_b[31:16], wheel_speed_c[47:32]
  output logic [47:0]      m_axis_tdata,
  output logic             m_axis_tuser     // saturated
);

  localparam int N        = SINE_INDEX_BITS;
  localparam int QUARTER  = 2 ** (N - 2);
  localparam int YW       = N + 11;
  localparam int RW       = 22;
  localparam int PW       = YW + RW;
  localparam int SW       = 38;
  localparam int NS       = 10;

  localparam logic [RW-1:0] RECIP = RW'((64'd1 << 32) / 64'(otwk_pkg::STEP_DIV));
  localparam logic signed [17:0] CIRC18  = 18'(otwk_pkg::FULL_CIRCLE);
  localparam logic signed [17:0] SIXTY18 = 18'(otwk_pkg::SIXTY_DEG);
  localparam logic [YW-1:0] STEP_DIV_Y   = YW'(otwk_pkg::STEP_DIV);
  localparam logic [YW-1:0] STEP_HALF_Y  = YW'(otwk_pkg::STEP_HALF);
  localparam logic [11:0]   STEP_DIV_R   = 12'(otwk_pkg::STEP_DIV);
  localparam logic [11:0]   STEP_TWICE_R = 12'(2 * otwk_pkg::STEP_DIV);
  localparam logic [N-1:0]  QUARTER_K    = N'(QUARTER);
  localparam logic [N-2:0]  QUARTER_M    = (N - 1)'(QUARTER);

  // Input fields.
  logic signed [15:0] in_heading;
  logic signed [11:0] in_vx;
  logic signed [11:0] in_vy;
  logic signed [11:0] in_turn;
  assign in_heading = s_axis_tdata[15:0];
  assign in_vx      = s_axis_tdata[27:16];
  assign in_vy      = s_axis_tdata[39:28];
  assign in_turn    = s_axis_tdata[51:40];

  // Pipeline flow control.
  logic [NS:1]   vld_q;
  logic [NS:1]   vld_in;
  logic [NS+1:1] adv;
  logic          in_fire;

  assign adv[NS+1] = m_axis_tready;
  for (genvar k = 1; k <= NS; k++) begin : g_adv
    assign adv[k] = ~vld_q[k] | adv[k+1];
  end
  assign vld_in        = {vld_q[NS-1:1], s_axis_tvalid};
  assign s_axis_tready = adv[1];
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // Lever register and reference heading.
  logic [15:0] lever_q;
  logic [15:0] ref_heading_q;
  logic        ref_taken_q;
  logic        capture;

  assign capture = ~ref_taken_q | s_axis_tuser;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lever_q       <= otwk_pkg::LEVER_RESET;
      ref_heading_q <= '0;
      ref_taken_q   <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        lever_q <= cfg_wr_data_i;
      end
      if (in_fire && capture) begin
        ref_heading_q <= in_heading;
        ref_taken_q   <= 1'b1;
      end
    end
  end

  // Stage 1: heading minus reference, lever times turn rate.
  logic signed [15:0] ref_sel;
  logic signed [16:0] diff1_q;
  otwk_pkg::side_t    side_q [1:8];

  assign ref_sel = capture ? in_heading : signed'(ref_heading_q);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      diff1_q             <= 17'(in_heading) - 17'(ref_sel);
      side_q[1].vx         <= in_vx;
      side_q[1].vy         <= in_vy;
      side_q[1].lever_turn <= $signed({1'b0, lever_q}) * in_turn;
    end
    for (int k = 2; k <= 8; k++) begin
      if (adv[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stage 2: wrap the difference into 0..35999.
  logic signed [17:0] wrap_d;
  logic [15:0]        theta2_q;

  always_comb begin
    wrap_d = 18'(diff1_q);
    if (wrap_d < 0) begin
      if (wrap_d + CIRC18 < 0) begin
        wrap_d = wrap_d + CIRC18 + CIRC18;
      end else begin
        wrap_d = wrap_d + CIRC18;
      end
    end else if (wrap_d >= CIRC18) begin
      wrap_d = wrap_d - CIRC18;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      theta2_q <= 16'(wrap_d);
    end
  end

  // Stage 3: the three wheel angles, scaled for the index quantizer.
  logic signed [17:0] ang_d [3];
  logic [YW-1:0]      y_d   [3];
  logic [YW-1:0]      y3_q  [3];

  always_comb begin
    ang_d[0] = 18'(theta2_q);
    ang_d[1] = SIXTY18 - 18'(theta2_q);
    if (ang_d[1] < 0) begin
      ang_d[1] = ang_d[1] + CIRC18;
    end
    ang_d[2] = SIXTY18 + 18'(theta2_q);
    if (ang_d[2] >= CIRC18) begin
      ang_d[2] = ang_d[2] - CIRC18;
    end
    for (int j = 0; j < 3; j++) begin
      y_d[j] = (YW'(ang_d[j][15:0]) << (N - 5)) + STEP_HALF_Y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      y3_q <= y_d;
    end
  end

  // Stage 4: multiply by the reciprocal of the step divisor.
  logic [PW-1:0] prod4_q [3];
  logic [YW-1:0] y4_q    [3];

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      for (int j = 0; j < 3; j++) begin
        prod4_q[j] <= PW'(y3_q[j]) * PW'(RECIP);
      end
      y4_q <= y3_q;
    end
  end

  // Stage 5: quotient estimate and its remainder.
  logic [N:0]  qe5_q  [3];
  logic [11:0] rem5_q [3];
  logic [N:0]  qe_d   [3];
  logic [YW-1:0] rem_d [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qe_d[j]  = prod4_q[j][PW-1:32];
      rem_d[j] = y4_q[j] - YW'(qe_d[j]) * STEP_DIV_Y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      qe5_q <= qe_d;
      for (int j = 0; j < 3; j++) begin
        rem5_q[j] <= rem_d[j][11:0];
      end
    end
  end

  // Stage 6: correct the estimate by one where needed.
  logic [N-1:0] k6_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      for (int j = 0; j < 3; j++) begin
        k6_q[j] <= N'(qe5_q[j] + (N + 1)'(rem5_q[j] >= STEP_DIV_R));
      end
    end
  end

  // Stage 7: sine and cosine from the quarter-wave table.
  logic [14:0] qsin [QUARTER+1];
  for (genvar g = 0; g <= QUARTER; g++) begin : g_qsin
    assign qsin[g] = otwk_pkg::quarter_sine(g, N);
  end

  function automatic logic signed [15:0] sine_at(input logic [N-1:0] idx);
    logic [N-2:0] mi;
    logic [15:0]  mag;
    mi  = idx[N-2] ? QUARTER_M - {1'b0, idx[N-3:0]} : {1'b0, idx[N-3:0]};
    mag = {1'b0, qsin[mi]};
    return idx[N-1] ? -signed'(mag) : signed'(mag);
  endfunction

  logic signed [15:0] sin7_q [3];
  logic signed [15:0] cos7_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      for (int j = 0; j < 3; j++) begin
        sin7_q[j] <= sine_at(k6_q[j]);
        cos7_q[j] <= sine_at(k6_q[j] + QUARTER_K);
      end
    end
  end

  // Stage 8: speed products.
  logic signed [27:0] ps8_q [3];
  logic signed [27:0] pc8_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      for (int j = 0; j < 3; j++) begin
        ps8_q[j] <= sin7_q[j] * $signed(side_q[7].vx);
        pc8_q[j] <= cos7_q[j] * $signed(side_q[7].vy);
      end
    end
  end

  // Stage 9: wheel sums in Q15.
  logic signed [SW-1:0] turn_d;
  logic signed [SW-1:0] sum9_q [3];

  assign turn_d = SW'($signed(side_q[8].lever_turn)) <<< 7;

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      sum9_q[0] <= SW'(ps8_q[0]) - SW'(pc8_q[0]) + turn_d;
      sum9_q[1] <= SW'(ps8_q[1]) + SW'(pc8_q[1]) + turn_d;
      sum9_q[2] <= SW'(pc8_q[2]) - SW'(ps8_q[2]) + turn_d;
    end
  end

  // Stage 10: round half up, saturate, output register.
  logic signed [SW-1:0] rnd_d  [3];
  logic signed [15:0]   wheel_d [3];
  logic [2:0]           clip_d;
  logic signed [15:0]   wheel_q [3];
  logic                 sat_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rnd_d[j] = (sum9_q[j] + SW'(16384)) >>> 15;
      clip_d[j] = 1'b0;
      if (rnd_d[j] > SW'(32767)) begin
        wheel_d[j] = 16'sh7fff;
        clip_d[j]  = 1'b1;
      end else if (rnd_d[j] < -SW'(32768)) begin
        wheel_d[j] = 16'sh8000;
        clip_d[j]  = 1'b1;
      end else begin
        wheel_d[j] = rnd_d[j][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      wheel_q <= wheel_d;
      sat_q   <= |clip_d;
    end
  end

  assign m_axis_tvalid = vld_q[NS];
  assign m_axis_tdata  = {wheel_q[2], wheel_q[1], wheel_q[0]};
  assign m_axis_tuser  = sat_q;

  // Once a reference exists it is never dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_taken_q |=> ref_taken_q)
    else $error("reference flag cleared outside reset");

  // Any accepted word leaves a reference behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ref_taken_q)
    else $error("word accepted without capturing a reference");

  // The wrapped heading difference lies on one circle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> theta2_q < 16'(otwk_pkg::FULL_CIRCLE))
    else $error("theta out of range");

  // The reciprocal estimate is low by at most one step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (rem5_q[0] < STEP_TWICE_R) && (rem5_q[1] < STEP_TWICE_R) &&
                 (rem5_q[2] < STEP_TWICE_R))
    else $error("index remainder out of range");

endmodule

`default_nettype wire
